FILE: rtl/hbc_pkg.sv
// hbc_pkg: shared constants and types of the hash bucket collision counter
// no dependencies; used by the top level and its checker
`default_nettype none

package hbc_pkg;

	// default log2 of the bitmap size
	localparam int MAX_BUCKET_BITS = 16;

	// bitmap rows hold 32 buckets each
	localparam int ROW_SEL_BITS = 5;
	localparam int ROW_BITS     = 1 << ROW_SEL_BITS;

	// widths of the configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 5;

	// saturation value of the collision counter
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SHIFT_FIRST  = 3'd0,
		REG_SHIFT_SECOND = 3'd1,
		REG_SHIFT_THIRD  = 3'd2,
		REG_SHIFT_FOURTH = 3'd3,
		REG_BUCKET_BITS  = 3'd4
	} reg_index_t;

	// input action codes
	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_CLEAR  = 1'b1
	} action_t;

endpackage

`default_nettype wire

FILE: rtl/hbc_ram.sv
// hbc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module hbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, and read returning the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/hash_bucket_collision_counter.sv
// hash_bucket_collision_counter: shift-add-xor hash, occupancy bitmap, collision count
// depends on hbc_pkg and hbc_ram
//
//  channel  signals                                          direction
//  ------   -----------------------------------------------  ---------
//  in       in_valid in_ready action word_code                 in
//  out      out_valid out_ready bucket_index collided          out
//           collision_count
//  cfg      cfg_we cfg_index cfg_data                          in
//
// one beat per cycle on both channels unless stalled
// the bitmap row read-modify-write in the last stage forwards to the next beat
// a clear beat, and reset, start a sweep of the 2^(MAX_BUCKET_BITS-5) bitmap rows (2 rows
// when MAX_BUCKET_BITS is 5 or less) that zeroes one bitmap row a cycle; in_ready
// is low from a clear beat's acceptance until its sweep ends
// a stalled out channel holds the whole pipeline
`default_nettype none

module hash_bucket_collision_counter #(
	parameter int MAX_BUCKET_BITS = hbc_pkg::MAX_BUCKET_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [hbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [hbc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic                                action,
	input  wire logic [31:0]                         word_code,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [15:0]                         bucket_index,
	output      logic                                collided,
	output      logic [31:0]                         collision_count
);

	localparam int IDX_W   = MAX_BUCKET_BITS;
	localparam int SEL_W   = hbc_pkg::ROW_SEL_BITS;
	localparam int ROW_W   = hbc_pkg::ROW_BITS;
	localparam int ADDR_W  = (IDX_W > SEL_W) ? IDX_W - SEL_W : 1;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int EXT_W   = IDX_W + SEL_W;
	localparam logic [4:0] MAX_BITS = 5'(MAX_BUCKET_BITS);

	// row address of a bucket
	function automatic logic [ADDR_W-1:0] row_of(input logic [IDX_W-1:0] idx);
		logic [EXT_W-1:0] ext;
		ext = {{SEL_W{1'b0}}, idx};
		return ext[ADDR_W+SEL_W-1:SEL_W];
	endfunction

	// bit position of a bucket within its row
	function automatic logic [SEL_W-1:0] sel_of(input logic [IDX_W-1:0] idx);
		logic [EXT_W-1:0] ext;
		ext = {{SEL_W{1'b0}}, idx};
		return ext[SEL_W-1:0];
	endfunction

	// configuration registers
	logic [4:0] shift_first_q;
	logic [4:0] shift_second_q;
	logic [4:0] shift_third_q;
	logic [4:0] shift_fourth_q;
	logic [4:0] bucket_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_first_q  <= '0;
			shift_second_q <= '0;
			shift_third_q  <= '0;
			shift_fourth_q <= '0;
			bucket_bits_q  <= 5'd7;
		end else if (cfg_we) begin
			case (hbc_pkg::reg_index_t'(cfg_index))
				hbc_pkg::REG_SHIFT_FIRST:  shift_first_q  <= cfg_data;
				hbc_pkg::REG_SHIFT_SECOND: shift_second_q <= cfg_data;
				hbc_pkg::REG_SHIFT_THIRD:  shift_third_q  <= cfg_data;
				hbc_pkg::REG_SHIFT_FOURTH: shift_fourth_q <= cfg_data;
				hbc_pkg::REG_BUCKET_BITS:  bucket_bits_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic act_s1, act_s2, act_s3, act_s4;
	logic out_valid_q;
	logic clear_busy_q;
	logic adv;
	logic clear_pending;
	logic in_fire;

	assign adv           = !out_valid_q || out_ready;
	assign clear_pending = (vld_s1 && act_s1) || (vld_s2 && act_s2) ||
	                       (vld_s3 && act_s3) || (vld_s4 && act_s4);
	assign in_ready      = adv && !clear_busy_q && !clear_pending;
	assign in_fire       = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_fire;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// hash stages: add-invert, then xor-add, then final xor and mask
	logic [31:0] h_s1, h_s2;
	logic [31:0] mix_a, mix_b;
	logic [4:0]  eff_bits;
	logic [IDX_W-1:0] mask;
	logic [IDX_W-1:0] idx_next;
	logic [IDX_W-1:0] idx_s3, idx_s4;

	assign mix_a = h_s1 ^ (h_s1 >> shift_second_q);
	assign mix_b = h_s2 ^ (h_s2 >> shift_fourth_q);
	assign eff_bits = (bucket_bits_q > MAX_BITS) ? MAX_BITS : bucket_bits_q;

	always_comb begin
		for (int i = 0; i < IDX_W; i++) begin
			mask[i] = (5'(i) < eff_bits);
		end
	end

	assign idx_next = mix_b[IDX_W-1:0] & mask;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= action;
			h_s1   <= word_code + ~(word_code << shift_first_q);
			act_s2 <= act_s1;
			h_s2   <= mix_a + (mix_a << shift_third_q);
			act_s3 <= act_s2;
			idx_s3 <= idx_next;
			act_s4 <= act_s3;
			idx_s4 <= idx_s3;
		end
	end

	// bitmap memory
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  ram_rdata;

	hbc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (adv),
		.raddr (row_of(idx_s3)),
		.rdata (ram_rdata)
	);

	// row read-modify-write with forwarding of the write made at the read edge
	logic              fwd_vld_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [ROW_W-1:0]  fwd_data_q;
	logic [ADDR_W-1:0] row_s4;
	logic [ROW_W-1:0]  row_data;
	logic [ROW_W-1:0]  row_new;
	logic              hit;
	logic              insert_wr;
	logic [31:0]       count_q;
	logic [31:0]       count_next;
	logic [ADDR_W-1:0] clr_addr_q;

	assign row_s4    = row_of(idx_s4);
	assign row_data  = (fwd_vld_q && (fwd_addr_q == row_s4)) ? fwd_data_q : ram_rdata;
	assign hit       = row_data[sel_of(idx_s4)];
	assign row_new   = row_data | (ROW_W'(1) << sel_of(idx_s4));
	assign insert_wr = adv && vld_s4 && (act_s4 == hbc_pkg::ACT_INSERT);
	assign count_next = (hit && (count_q != hbc_pkg::COUNT_MAX)) ? count_q + 32'd1 : count_q;

	// write port: clearing sweep or insert write-back
	always_comb begin
		if (clear_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = insert_wr;
			ram_waddr = row_s4;
			ram_wdata = row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (clear_busy_q) begin
			fwd_vld_q <= 1'b0;
		end else if (adv) begin
			fwd_vld_q <= insert_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q <= row_s4;
			fwd_data_q <= row_new;
		end
	end

	// clearing sweep, started by reset and by a clear beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clear_busy_q) begin
			if (clr_addr_q == {ADDR_W{1'b1}}) begin
				clear_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end else if (adv && vld_s4 && (act_s4 == hbc_pkg::ACT_CLEAR)) begin
			clear_busy_q <= 1'b1;
			clr_addr_q   <= '0;
		end
	end

	// collision counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv && vld_s4) begin
			count_q <= (act_s4 == hbc_pkg::ACT_CLEAR) ? '0 : count_next;
		end
	end

	// output register
	logic [IDX_W+15:0] idx_wide;
	logic [15:0]       bucket_index_q;
	logic              collided_q;
	logic [31:0]       collision_count_q;

	assign idx_wide = {16'b0, idx_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (act_s4 == hbc_pkg::ACT_CLEAR) begin
				bucket_index_q    <= '0;
				collided_q        <= 1'b0;
				collision_count_q <= '0;
			end else begin
				bucket_index_q    <= idx_wide[15:0];
				collided_q        <= hit;
				collision_count_q <= count_next;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign bucket_index    = bucket_index_q;
	assign collided        = collided_q;
	assign collision_count = collision_count_q;

endmodule

`default_nettype wire

FILE: rtl/hbc_checker.sv
// hbc_assert: port-level assertions for the hash bucket collision counter
// depends on hbc_pkg; bound to hash_bucket_collision_counter at the end of this file
`default_nettype none

module hbc_assert (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] bucket_index,
	input wire logic        collided,
	input wire logic [31:0] collision_count
);

	// count carried by the last delivered result beat
	logic [31:0] last_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (out_valid && out_ready) begin
			last_count_q <= collision_count;
		end
	end

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bucket_index) &&
		$stable(collided) && $stable(collision_count))
		else $error("result changed while stalled");

	// no collision keeps the count, or a clear zeroes it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !collided |->
		(collision_count == last_count_q) || (collision_count == 32'd0))
		else $error("count moved without a collision");

	// a collision bumps the count by one or holds it at saturation
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && collided |->
		({1'b0, collision_count} == {1'b0, last_count_q} + 33'd1) ||
		((last_count_q == hbc_pkg::COUNT_MAX) && (collision_count == hbc_pkg::COUNT_MAX)))
		else $error("collision did not advance the count by one");

	// the bitmap sweep after reset keeps the input closed
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) == 1'b0 |-> !in_ready)
		else $error("input opened before the bitmap sweep");

endmodule

bind hash_bucket_collision_counter hbc_assert u_hbc_assert (.*);

`default_nettype wire
